// ===== src/vpsn_pkg.sv =====
// Shared types and codes for the vector path segment normalizer.
// No dependencies; imported by every module of the block.
package vpsn_pkg;

	localparam int NUM_ARGS = 7;
	localparam int REFLECT_GAIN = 2;

	typedef logic signed [31:0] coord_t;

	typedef enum logic [3:0] {
		KIND_BEGIN   = 4'd0,
		KIND_MOVE    = 4'd1,
		KIND_LINE    = 4'd2,
		KIND_HORIZ   = 4'd3,
		KIND_VERT    = 4'd4,
		KIND_CUBIC   = 4'd5,
		KIND_SCUBIC  = 4'd6,
		KIND_QUAD    = 4'd7,
		KIND_SQUAD   = 4'd8,
		KIND_ARC     = 4'd9,
		KIND_CLOSE   = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		PRIM_MOVE  = 3'd0,
		PRIM_LINE  = 3'd1,
		PRIM_CUBIC = 3'd2,
		PRIM_QUAD  = 3'd3,
		PRIM_ARC   = 3'd4,
		PRIM_CLOSE = 3'd5
	} prim_t;

	typedef enum logic [1:0] {
		CLASS_NONE  = 2'd0,
		CLASS_CUBIC = 2'd1,
		CLASS_QUAD  = 2'd2
	} curve_class_t;

	typedef struct packed {
		coord_t       cur_x;
		coord_t       cur_y;
		coord_t       start_x;
		coord_t       start_y;
		coord_t       ctl_x;
		coord_t       ctl_y;
		logic [1:0]   pclass;
	} path_state_t;

	typedef struct packed {
		logic [2:0] prim;
		coord_t     o0;
		coord_t     o1;
		coord_t     o2;
		coord_t     o3;
		coord_t     o4;
		coord_t     o5;
		coord_t     o6;
	} prim_res_t;

endpackage

// ===== src/vpsn_add_lane.sv =====
// One saturating adder lane: origin plus operand, clamped to 32 bits.
// Depends on vpsn_pkg.
module vpsn_add_lane (
	input  vpsn_pkg::coord_t origin,
	input  vpsn_pkg::coord_t operand,
	output vpsn_pkg::coord_t sum
);
	import vpsn_pkg::*;

	logic signed [32:0] wide;

	assign wide = {origin[31], origin} + {operand[31], operand};

	always_comb begin
		if (wide[32] != wide[31]) begin
			sum = wide[32] ? coord_t'({1'b1, 31'd0}) : coord_t'({1'b0, {31{1'b1}}});
		end else begin
			sum = wide[31:0];
		end
	end
endmodule

// ===== src/vpsn_reflect_lane.sv =====
// Reflection lane: mirrors a control point about the current point, saturating.
// Depends on vpsn_pkg.
module vpsn_reflect_lane (
	input  vpsn_pkg::coord_t cur,
	input  vpsn_pkg::coord_t ctl,
	output vpsn_pkg::coord_t mirrored
);
	import vpsn_pkg::*;

	logic signed [33:0] cur_w;
	logic signed [33:0] ctl_w;
	logic signed [33:0] diff;

	assign cur_w = {{2{cur[31]}}, cur};
	assign ctl_w = {{2{ctl[31]}}, ctl};
	assign diff  = cur_w * 34'(REFLECT_GAIN) - ctl_w;

	always_comb begin
		// in range only when the top three bits agree
		if ((diff[33:31] == 3'b000) || (diff[33:31] == 3'b111)) begin
			mirrored = diff[31:0];
		end else begin
			mirrored = diff[33] ? coord_t'({1'b1, 31'd0}) : coord_t'({1'b0, {31{1'b1}}});
		end
	end
endmodule

// ===== src/vpsn_merge.sv =====
// Merge stage: picks lane results into the primitive and the next path state.
// Depends on vpsn_pkg.
module vpsn_merge (
	input  logic [3:0]           kind,
	input  logic                 continued,
	input  vpsn_pkg::coord_t     args [vpsn_pkg::NUM_ARGS],
	input  vpsn_pkg::coord_t     sums [vpsn_pkg::NUM_ARGS],
	input  vpsn_pkg::coord_t     refl_x,
	input  vpsn_pkg::coord_t     refl_y,
	input  vpsn_pkg::path_state_t st,
	output vpsn_pkg::path_state_t st_next,
	output vpsn_pkg::prim_res_t  res,
	output logic                 has_res
);
	import vpsn_pkg::*;

	always_comb begin
		st_next = st;
		has_res = 1'b1;
		res     = '0;
		case (kind)
			KIND_BEGIN: begin
				st_next = '0;
				has_res = 1'b0;
			end
			KIND_MOVE, KIND_LINE: begin
				st_next.cur_x  = sums[0];
				st_next.cur_y  = sums[1];
				st_next.pclass = CLASS_NONE;
				res.o0 = sums[0];
				res.o1 = sums[1];
				if (kind == KIND_MOVE && !continued) begin
					res.prim        = PRIM_MOVE;
					st_next.start_x = sums[0];
					st_next.start_y = sums[1];
				end else begin
					res.prim = PRIM_LINE;
				end
			end
			KIND_HORIZ: begin
				st_next.cur_x  = sums[0];
				st_next.pclass = CLASS_NONE;
				res.prim = PRIM_LINE;
				res.o0   = sums[0];
				res.o1   = st.cur_y;
			end
			KIND_VERT: begin
				// lane 0 runs off the y origin for this kind
				st_next.cur_y  = sums[0];
				st_next.pclass = CLASS_NONE;
				res.prim = PRIM_LINE;
				res.o0   = st.cur_x;
				res.o1   = sums[0];
			end
			KIND_CUBIC: begin
				res.prim = PRIM_CUBIC;
				res.o0 = sums[0];
				res.o1 = sums[1];
				res.o2 = sums[2];
				res.o3 = sums[3];
				res.o4 = sums[4];
				res.o5 = sums[5];
				st_next.ctl_x  = sums[2];
				st_next.ctl_y  = sums[3];
				st_next.cur_x  = sums[4];
				st_next.cur_y  = sums[5];
				st_next.pclass = CLASS_CUBIC;
			end
			KIND_SCUBIC: begin
				res.prim = PRIM_CUBIC;
				if (st.pclass == CLASS_CUBIC) begin
					res.o0 = refl_x;
					res.o1 = refl_y;
				end else begin
					res.o0 = st.cur_x;
					res.o1 = st.cur_y;
				end
				res.o2 = sums[0];
				res.o3 = sums[1];
				res.o4 = sums[2];
				res.o5 = sums[3];
				st_next.ctl_x  = sums[0];
				st_next.ctl_y  = sums[1];
				st_next.cur_x  = sums[2];
				st_next.cur_y  = sums[3];
				st_next.pclass = CLASS_CUBIC;
			end
			KIND_QUAD: begin
				res.prim = PRIM_QUAD;
				res.o0 = sums[0];
				res.o1 = sums[1];
				res.o2 = sums[2];
				res.o3 = sums[3];
				st_next.ctl_x  = sums[0];
				st_next.ctl_y  = sums[1];
				st_next.cur_x  = sums[2];
				st_next.cur_y  = sums[3];
				st_next.pclass = CLASS_QUAD;
			end
			KIND_SQUAD: begin
				res.prim = PRIM_QUAD;
				if (st.pclass == CLASS_QUAD) begin
					res.o0 = refl_x;
					res.o1 = refl_y;
				end else begin
					res.o0 = st.cur_x;
					res.o1 = st.cur_y;
				end
				res.o2 = sums[0];
				res.o3 = sums[1];
				st_next.ctl_x  = res.o0;
				st_next.ctl_y  = res.o1;
				st_next.cur_x  = sums[0];
				st_next.cur_y  = sums[1];
				st_next.pclass = CLASS_QUAD;
			end
			KIND_ARC: begin
				// radii, rotation and flags pass through
				res.prim = PRIM_ARC;
				res.o0 = args[0];
				res.o1 = args[1];
				res.o2 = args[2];
				res.o3 = args[3];
				res.o4 = args[4];
				res.o5 = sums[5];
				res.o6 = sums[6];
				st_next.cur_x  = sums[5];
				st_next.cur_y  = sums[6];
				st_next.pclass = CLASS_NONE;
			end
			KIND_CLOSE: begin
				res.prim = PRIM_CLOSE;
				st_next.cur_x  = st.start_x;
				st_next.cur_y  = st.start_y;
				st_next.pclass = CLASS_NONE;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end
endmodule

// ===== src/vector_path_segment_normalizer.sv =====
// Vector path segment normalizer: one tokenized path segment in per request,
// at most one absolute primitive out. A segment is taken every cycle while
// seg_stall is low; its primitive is registered into the output register, or,
// while a result is stalled, into a skid register that lets one more request in.
// Seven saturating adder lanes and two reflection lanes work on the operands in
// parallel and a merge stage updates the path state in the same cycle, so the
// state loop through that stage is what sets the one-request-per-cycle rate;
// begin-path and unknown kinds produce no result.
// Depends on vpsn_pkg, vpsn_add_lane, vpsn_reflect_lane, vpsn_merge.
module vector_path_segment_normalizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_valid,
	output logic                seg_stall,
	input  logic [3:0]          kind,
	input  logic                relative,
	input  logic                continued,
	input  vpsn_pkg::coord_t    arg0,
	input  vpsn_pkg::coord_t    arg1,
	input  vpsn_pkg::coord_t    arg2,
	input  vpsn_pkg::coord_t    arg3,
	input  vpsn_pkg::coord_t    arg4,
	input  vpsn_pkg::coord_t    arg5,
	input  vpsn_pkg::coord_t    arg6,
	output logic                prim_valid,
	input  logic                prim_stall,
	output logic [2:0]          primitive_res,
	output vpsn_pkg::coord_t    out0,
	output vpsn_pkg::coord_t    out1,
	output vpsn_pkg::coord_t    out2,
	output vpsn_pkg::coord_t    out3,
	output vpsn_pkg::coord_t    out4,
	output vpsn_pkg::coord_t    out5,
	output vpsn_pkg::coord_t    out6
);
	import vpsn_pkg::*;

	path_state_t state_q;
	path_state_t state_next;
	prim_res_t   res;
	logic        has_res;
	prim_res_t   out_q;
	prim_res_t   skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	coord_t args    [NUM_ARGS];
	coord_t origins [NUM_ARGS];
	coord_t sums    [NUM_ARGS];
	coord_t org_x;
	coord_t org_y;
	coord_t refl_x;
	coord_t refl_y;

	logic seg_acc;
	logic take;
	logic produce;

	assign args[0] = arg0;
	assign args[1] = arg1;
	assign args[2] = arg2;
	assign args[3] = arg3;
	assign args[4] = arg4;
	assign args[5] = arg5;
	assign args[6] = arg6;

	assign org_x = relative ? state_q.cur_x : '0;
	assign org_y = relative ? state_q.cur_y : '0;

	// even lanes are x, odd lanes y; vertical line puts its y on lane 0,
	// arc puts its end x on lane 5
	assign origins[0] = (kind == KIND_VERT) ? org_y : org_x;
	assign origins[1] = org_y;
	assign origins[2] = org_x;
	assign origins[3] = org_y;
	assign origins[4] = org_x;
	assign origins[5] = (kind == KIND_ARC) ? org_x : org_y;
	assign origins[6] = org_y;

	for (genvar i = 0; i < NUM_ARGS; i++) begin : g_lane
		vpsn_add_lane u_lane (
			.origin  (origins[i]),
			.operand (args[i]),
			.sum     (sums[i])
		);
	end

	vpsn_reflect_lane u_refl_x (
		.cur      (state_q.cur_x),
		.ctl      (state_q.ctl_x),
		.mirrored (refl_x)
	);

	vpsn_reflect_lane u_refl_y (
		.cur      (state_q.cur_y),
		.ctl      (state_q.ctl_y),
		.mirrored (refl_y)
	);

	vpsn_merge u_merge (
		.kind      (kind),
		.continued (continued),
		.args      (args),
		.sums      (sums),
		.refl_x    (refl_x),
		.refl_y    (refl_y),
		.st        (state_q),
		.st_next   (state_next),
		.res       (res),
		.has_res   (has_res)
	);

	assign seg_stall = skid_valid_q;
	assign seg_acc   = seg_valid & ~skid_valid_q;
	assign take      = out_valid_q & ~prim_stall;
	assign produce   = seg_acc & has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (seg_acc) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (produce) begin
				out_q <= res;
			end
		end else if (produce) begin
			skid_q <= res;
		end
	end

	assign prim_valid    = out_valid_q;
	assign primitive_res = out_q.prim;
	assign out0          = out_q.o0;
	assign out1          = out_q.o1;
	assign out2          = out_q.o2;
	assign out3          = out_q.o3;
	assign out4          = out_q.o4;
	assign out5          = out_q.o5;
	assign out6          = out_q.o6;
endmodule

// ===== test/tb_vector_path_segment_normalizer.sv =====
// Testbench for vector_path_segment_normalizer: directed and random path segments,
// each checked against a predictor of the path state kept in this file.
// Depends on vpsn_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_vector_path_segment_normalizer;
	import vpsn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1450;
	localparam coord_t C_MAX = 32'sh7fffffff;
	localparam coord_t C_MIN = 32'sh80000000;
	localparam coord_t ONE = 32'sh00010000;

	typedef logic [6:0][31:0] operands_t;

	typedef struct packed {
		logic [2:0] prim;
		operands_t  outs;
	} prim_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seg_valid = 1'b0;
	logic        seg_stall;
	logic [3:0]  kind = '0;
	logic        relative = 1'b0;
	logic        continued = 1'b0;
	coord_t      arg0 = '0, arg1 = '0, arg2 = '0, arg3 = '0;
	coord_t      arg4 = '0, arg5 = '0, arg6 = '0;
	logic        prim_valid;
	logic        prim_stall = 1'b0;
	logic [2:0]  primitive_res;
	coord_t      out0, out1, out2, out3, out4, out5, out6;

	// predictor copy of the path state
	coord_t       pen_x, pen_y, sub_x, sub_y, ctl_x, ctl_y;
	curve_class_t prev_curve;

	prim_expect_t expected_prims[$];
	int           errors = 0;
	int           items_sent = 0;
	int           rx_wait = 0;
	int           cycle_count = 0;
	bit           no_idle = 1'b0;

	vector_path_segment_normalizer DUT (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall),
		.kind(kind), .relative(relative), .continued(continued),
		.arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3),
		.arg4(arg4), .arg5(arg5), .arg6(arg6),
		.prim_valid(prim_valid), .prim_stall(prim_stall),
		.primitive_res(primitive_res),
		.out0(out0), .out1(out1), .out2(out2), .out3(out3),
		.out4(out4), .out5(out5), .out6(out6)
	);

	always #4 clk = ~clk;

	function automatic coord_t clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return C_MAX;
		if (v < -64'sd2147483648)
			return C_MIN;
		return v[31:0];
	endfunction

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		return clamp_coord(longint'(a) + longint'(b));
	endfunction

	function automatic coord_t mirror_ctl(input coord_t cur, input coord_t ctl);
		return clamp_coord(longint'(REFLECT_GAIN) * longint'(cur) - longint'(ctl));
	endfunction

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			3, 4, 5: return $urandom_range(0, 400 << 16) - (200 << 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic operands_t rand_operands();
		operands_t ops;
		for (int i = 0; i < 7; i++)
			ops[i] = rand_coord();
		return ops;
	endfunction

	function automatic operands_t pack_ops(input coord_t a0, input coord_t a1,
			input coord_t a2, input coord_t a3, input coord_t a4, input coord_t a5,
			input coord_t a6);
		operands_t ops;
		ops[0] = a0; ops[1] = a1; ops[2] = a2; ops[3] = a3;
		ops[4] = a4; ops[5] = a5; ops[6] = a6;
		return ops;
	endfunction

	function automatic void clear_path();
		pen_x = '0; pen_y = '0;
		sub_x = '0; sub_y = '0;
		ctl_x = '0; ctl_y = '0;
		prev_curve = CLASS_NONE;
	endfunction

	// Update the path state for one accepted segment and queue its primitive.
	function automatic void normalize_segment(input logic [3:0] k, input logic r,
			input logic c, input operands_t ops);
		coord_t       ox, oy;
		operands_t    o;
		logic [2:0]   pr;
		bit           emit;
		prim_expect_t item;
		ox = r ? pen_x : '0;
		oy = r ? pen_y : '0;
		o = '0;
		pr = PRIM_LINE;
		emit = 1'b1;
		case (kind_t'(k))
			KIND_BEGIN: begin
				clear_path();
				emit = 1'b0;
			end
			KIND_MOVE, KIND_LINE: begin
				pen_x = sat_add(ox, ops[0]);
				pen_y = sat_add(oy, ops[1]);
				o[0] = pen_x;
				o[1] = pen_y;
				// only the first group of a moveto starts a subpath
				if (kind_t'(k) == KIND_MOVE && !c) begin
					pr = PRIM_MOVE;
					sub_x = pen_x;
					sub_y = pen_y;
				end
				prev_curve = CLASS_NONE;
			end
			KIND_HORIZ: begin
				pen_x = sat_add(ox, ops[0]);
				o[0] = pen_x;
				o[1] = pen_y;
				prev_curve = CLASS_NONE;
			end
			KIND_VERT: begin
				pen_y = sat_add(oy, ops[0]);
				o[0] = pen_x;
				o[1] = pen_y;
				prev_curve = CLASS_NONE;
			end
			KIND_CUBIC: begin
				for (int i = 0; i < 6; i += 2) begin
					o[i] = sat_add(ox, ops[i]);
					o[i + 1] = sat_add(oy, ops[i + 1]);
				end
				ctl_x = o[2]; ctl_y = o[3];
				pen_x = o[4]; pen_y = o[5];
				pr = PRIM_CUBIC;
				prev_curve = CLASS_CUBIC;
			end
			KIND_SCUBIC: begin
				if (prev_curve == CLASS_CUBIC) begin
					o[0] = mirror_ctl(pen_x, ctl_x);
					o[1] = mirror_ctl(pen_y, ctl_y);
				end else begin
					o[0] = pen_x;
					o[1] = pen_y;
				end
				o[2] = sat_add(ox, ops[0]);
				o[3] = sat_add(oy, ops[1]);
				o[4] = sat_add(ox, ops[2]);
				o[5] = sat_add(oy, ops[3]);
				ctl_x = o[2]; ctl_y = o[3];
				pen_x = o[4]; pen_y = o[5];
				pr = PRIM_CUBIC;
				prev_curve = CLASS_CUBIC;
			end
			KIND_QUAD: begin
				o[0] = sat_add(ox, ops[0]);
				o[1] = sat_add(oy, ops[1]);
				o[2] = sat_add(ox, ops[2]);
				o[3] = sat_add(oy, ops[3]);
				ctl_x = o[0]; ctl_y = o[1];
				pen_x = o[2]; pen_y = o[3];
				pr = PRIM_QUAD;
				prev_curve = CLASS_QUAD;
			end
			KIND_SQUAD: begin
				if (prev_curve == CLASS_QUAD) begin
					o[0] = mirror_ctl(pen_x, ctl_x);
					o[1] = mirror_ctl(pen_y, ctl_y);
				end else begin
					o[0] = pen_x;
					o[1] = pen_y;
				end
				o[2] = sat_add(ox, ops[0]);
				o[3] = sat_add(oy, ops[1]);
				ctl_x = o[0]; ctl_y = o[1];
				pen_x = o[2]; pen_y = o[3];
				pr = PRIM_QUAD;
				prev_curve = CLASS_QUAD;
			end
			KIND_ARC: begin
				// radii, rotation and flags pass through, end point made absolute
				for (int i = 0; i < 5; i++)
					o[i] = ops[i];
				o[5] = sat_add(ox, ops[5]);
				o[6] = sat_add(oy, ops[6]);
				pen_x = o[5]; pen_y = o[6];
				pr = PRIM_ARC;
				prev_curve = CLASS_NONE;
			end
			KIND_CLOSE: begin
				pen_x = sub_x;
				pen_y = sub_y;
				pr = PRIM_CLOSE;
				prev_curve = CLASS_NONE;
			end
			default: emit = 1'b0;
		endcase
		if (emit) begin
			item.prim = pr;
			item.outs = o;
			expected_prims.push_back(item);
		end
	endfunction

	task automatic send_segment(input logic [3:0] k, input logic r, input logic c,
			input operands_t ops);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_valid <= 1'b1;
		kind <= k;
		relative <= r;
		continued <= c;
		arg0 <= ops[0]; arg1 <= ops[1]; arg2 <= ops[2]; arg3 <= ops[3];
		arg4 <= ops[4]; arg5 <= ops[5]; arg6 <= ops[6];
		do
			@(posedge clk);
		while (seg_stall);
		normalize_segment(k, r, c, ops);
		items_sent++;
	endtask

	task automatic wait_for_drain();
		seg_valid <= 1'b0;
		@(posedge clk);
		while (expected_prims.size() > 0)
			@(posedge clk);
	endtask

	task automatic check_primitive();
		prim_expect_t want;
		operands_t    seen;
		seen = {out6, out5, out4, out3, out2, out1, out0};
		if (expected_prims.size() == 0) begin
			$error("unexpected primitive: primitive_res %0d", primitive_res);
			errors++;
		end else begin
			want = expected_prims.pop_front();
			if (primitive_res !== want.prim) begin
				$error("primitive_res: expected %0d, got %0d", want.prim, primitive_res);
				errors++;
			end
			for (int i = 0; i < 7; i++)
				if (seen[i] !== want.outs[i]) begin
					$error("out%0d: expected %h, got %h", i, want.outs[i], seen[i]);
					errors++;
				end
		end
	endtask

	// result side: check each accepted primitive, then draw the next stall
	always @(posedge clk) begin
		if (arst_n && prim_valid && !prim_stall) begin
			check_primitive();
			rx_wait = draw_wait();
		end else if (rx_wait > 0)
			rx_wait--;
		prim_stall <= arst_n && (rx_wait > 0);
	end

	task automatic test_directed_segments();
		send_segment(KIND_BEGIN, 1'b0, 1'b0, rand_operands());
		send_segment(KIND_MOVE, 1'b0, 1'b0, pack_ops(10 * ONE, -5 * ONE, 0, 0, 0, 0, 0));
		// repeated moveto group, relative, saturating
		send_segment(KIND_MOVE, 1'b1, 1'b1, pack_ops(C_MAX, C_MIN, 0, 0, 0, 0, 0));
		send_segment(KIND_LINE, 1'b1, 1'b0, pack_ops(C_MIN, C_MAX, 0, 0, 0, 0, 0));
		send_segment(KIND_HORIZ, 1'b1, 1'b0, pack_ops(3 * ONE, C_MAX, 0, 0, 0, 0, 0));
		send_segment(KIND_VERT, 1'b0, 1'b0, pack_ops(C_MIN, C_MAX, 0, 0, 0, 0, 0));
		send_segment(KIND_CUBIC, 1'b1, 1'b0,
			pack_ops(ONE, ONE, C_MAX, C_MAX, 2 * ONE, -2 * ONE, C_MIN));
		// control at the extremes so that the reflection saturates
		send_segment(KIND_CUBIC, 1'b0, 1'b0, pack_ops(0, 0, C_MIN, C_MAX, C_MAX, C_MIN, 0));
		send_segment(KIND_SCUBIC, 1'b0, 1'b0, pack_ops(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0));
		send_segment(KIND_SCUBIC, 1'b1, 1'b0, pack_ops(-ONE, ONE, 5 * ONE, -7 * ONE, 0, 0, 0));
		send_segment(KIND_LINE, 1'b0, 1'b1, pack_ops(20 * ONE, 30 * ONE, 0, 0, 0, 0, 0));
		send_segment(KIND_SCUBIC, 1'b0, 1'b0, pack_ops(ONE, ONE, 2 * ONE, 2 * ONE, 0, 0, 0));
		send_segment(KIND_QUAD, 1'b1, 1'b0, pack_ops(4 * ONE, 0, 8 * ONE, 8 * ONE, 0, 0, 0));
		send_segment(KIND_SQUAD, 1'b0, 1'b0, pack_ops(C_MAX, C_MIN, 0, 0, 0, 0, 0));
		send_segment(KIND_SQUAD, 1'b1, 1'b0, pack_ops(C_MIN, C_MAX, 0, 0, 0, 0, 0));
		// smooth segments of the other curve class: no reflection
		send_segment(KIND_SCUBIC, 1'b0, 1'b0, pack_ops(ONE, 0, 2 * ONE, 0, 0, 0, 0));
		send_segment(KIND_SQUAD, 1'b0, 1'b0, pack_ops(-3 * ONE, 9 * ONE, 0, 0, 0, 0, 0));
		send_segment(KIND_ARC, 1'b0, 1'b0, pack_ops(5 * ONE, 3 * ONE, 45 * ONE, 0, 1, ONE, ONE));
		send_segment(KIND_ARC, 1'b1, 1'b0, pack_ops(C_MAX, C_MIN, C_MIN, 1, 0, C_MAX, C_MIN));
		send_segment(KIND_CLOSE, 1'b1, 1'b1, rand_operands());
		send_segment(4'd11, 1'b1, 1'b0, rand_operands());
		send_segment(4'd15, 1'b0, 1'b1, rand_operands());
		send_segment(KIND_MOVE, 1'b1, 1'b0, pack_ops(-ONE, 7 * ONE, 0, 0, 0, 0, 0));
		send_segment(KIND_CLOSE, 1'b0, 1'b0, '0);
		send_segment(KIND_BEGIN, 1'b1, 1'b1, rand_operands());
		send_segment(KIND_CLOSE, 1'b0, 1'b0, '0);
	endtask

	task automatic send_random_path();
		int         n;
		logic [3:0] k;
		logic [3:0] last_k;
		logic       c;
		operands_t  ops;
		if ($urandom_range(0, 3) == 0)
			send_segment(KIND_BEGIN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				rand_operands());
		send_segment(KIND_MOVE, 1'($urandom_range(0, 1)), 1'b0, rand_operands());
		last_k = KIND_MOVE;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			ops = rand_operands();
			c = 1'($urandom_range(0, 1));
			if (last_k == KIND_CUBIC || last_k == KIND_SCUBIC)
				k = ($urandom_range(0, 1) != 0) ? KIND_SCUBIC
					: 4'($urandom_range(KIND_MOVE, KIND_CLOSE));
			else if (last_k == KIND_QUAD || last_k == KIND_SQUAD)
				k = ($urandom_range(0, 1) != 0) ? KIND_SQUAD
					: 4'($urandom_range(KIND_MOVE, KIND_CLOSE));
			else
				k = 4'($urandom_range(KIND_MOVE, KIND_CLOSE));
			// a moveto inside a path is usually a repeated group
			if (k == KIND_MOVE)
				c = ($urandom_range(0, 3) != 0);
			if (k == KIND_ARC && $urandom_range(0, 4) != 0) begin
				ops[3] = $urandom_range(0, 1);
				ops[4] = $urandom_range(0, 1);
			end
			// broken sequence: stray begin or unknown kind
			if ($urandom_range(0, 19) == 0)
				k = ($urandom_range(0, 1) != 0) ? KIND_BEGIN : 4'($urandom_range(11, 15));
			send_segment(k, 1'($urandom_range(0, 1)), c, ops);
			last_k = k;
		end
	endtask

	task automatic test_random_paths();
		int target;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			no_idle = ($urandom_range(0, 5) == 0);
			send_random_path();
			if ($urandom_range(0, 15) == 0)
				wait_for_drain();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++)
			send_random_path();
		wait_for_drain();
		for (int i = 0; i < 5; i++)
			send_random_path();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		for (int i = 0; i < 15; i++)
			send_random_path();
		no_idle = 1'b0;
	endtask

	task automatic test_noise();
		for (int i = 0; i < 150; i++)
			send_segment(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)),
				{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
	endtask

	initial begin
		clear_path();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_segments();
		test_random_paths();
		test_drain_pause();
		test_back_to_back();
		test_noise();
		wait_for_drain();
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
